FILE: rtl/pidrt_pkg.sv
// Package for the pid-keyed reference-counted handle table.
// Holds command, status and operation codes and the front-to-back work type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pidrt_pkg;

  localparam int HANDLE_W = 32;
  localparam int SIDX_W   = 8;
  localparam int SLOT_W   = 3;
  localparam int FREED_W  = 4;

  localparam logic [1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_DESTROY = 2'd2;
  localparam logic [1:0] CMD_CHECK   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SLOT   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NO_ALLOC  = 2'd3;

  localparam logic [2:0] OP_NOP     = 3'd0;
  localparam logic [2:0] OP_NEW     = 3'd1;
  localparam logic [2:0] OP_ACQ     = 3'd2;
  localparam logic [2:0] OP_REL     = 3'd3;
  localparam logic [2:0] OP_DESTROY = 3'd4;
  localparam logic [2:0] OP_CHECK   = 3'd5;

  typedef struct packed {
    logic [2:0]          op;
    logic [1:0]          status;
    logic [SIDX_W-1:0]   idx;
    logic                set_owner;
    logic                bump;
    logic                clr_owner;
    logic [HANDLE_W-1:0] handle;
  } work_t;

endpackage
`default_nettype wire

FILE: rtl/pidrt_queue.sv
// Two-entry queue between the classify front and the execute back.
// Carries packed work requests; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pidrt_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty,
  output logic              full
);

  logic [W-1:0] slot_q [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;
  logic [1:0]   cnt_nxt;

  assign empty    = (cnt_r == 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign pop_data = slot_q[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !full && !(pop && !empty)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!(push && !full) && pop && !empty) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push && !full) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && !empty) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_q[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pidrt_front.sv
// Front of the handle table: takes a request, matches keys against all
// entries and classifies it into a work request. Uses pidrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pidrt_front #(
  parameter int ENTRIES  = 8,
  parameter int PID_BITS = 22
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  in_cmd,
  input  wire logic [PID_BITS-1:0]         in_key_pid,
  input  wire logic [PID_BITS-1:0]         in_caller_pid,
  input  wire logic [pidrt_pkg::SIDX_W-1:0] in_slot_index,
  input  wire logic                        in_alloc_ok,
  input  wire logic [pidrt_pkg::HANDLE_W-1:0] in_alloc_handle,
  input  wire logic [ENTRIES-1:0]          live,
  input  wire logic [ENTRIES-1:0]          holds,
  input  wire logic [ENTRIES*PID_BITS-1:0] keys,
  input  wire logic                        q_empty,
  output logic                             push,
  output pidrt_pkg::work_t                 push_work,
  output logic [PID_BITS-1:0]              push_pid
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic                              hold_r;
  logic [1:0]                        cmd_r;
  logic [PID_BITS-1:0]               key_r;
  logic [PID_BITS-1:0]               caller_r;
  logic [pidrt_pkg::SIDX_W-1:0]      sidx_r;
  logic                              aok_r;
  logic [pidrt_pkg::HANDLE_W-1:0]    ahandle_r;

  logic [PID_BITS-1:0] pid;
  logic [ENTRIES-1:0]  hit_vec;
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    free_idx;
  logic                hit_any;
  logic                free_any;
  logic                is_owner;
  logic                holds_h;

  assign busy = hold_r;
  assign push = hold_r && q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (start && !hold_r) begin
      hold_r <= 1'b1;
    end else if (push) begin
      hold_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !hold_r) begin
      cmd_r     <= in_cmd;
      key_r     <= in_key_pid;
      caller_r  <= in_caller_pid;
      sidx_r    <= in_slot_index;
      aok_r     <= in_alloc_ok;
      ahandle_r <= in_alloc_handle;
    end
  end

  always_comb begin
    pid      = (key_r == '0) ? caller_r : key_r;
    is_owner = (pid == caller_r);
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      hit_vec[i] = live[i] && (keys[i*PID_BITS +: PID_BITS] == pid);
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!live[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    hit_any  = |hit_vec;
    free_any = ~&live;
    holds_h  = holds[hit_idx];
  end

  always_comb begin
    push_work           = '0;
    push_work.op        = pidrt_pkg::OP_NOP;
    push_work.status    = pidrt_pkg::ST_OK;
    push_work.handle    = ahandle_r;
    push_pid            = caller_r;
    case (cmd_r)
      pidrt_pkg::CMD_ACQUIRE: begin
        if (hit_any) begin
          push_work.op  = pidrt_pkg::OP_ACQ;
          push_work.idx = pidrt_pkg::SIDX_W'(hit_idx);
          if (is_owner) begin
            push_work.set_owner = !holds_h;
            push_work.bump      = !holds_h;
          end else begin
            push_work.bump = 1'b1;
          end
        end else if (key_r != '0) begin
          push_work.status = pidrt_pkg::ST_NOT_FOUND;
        end else if (!free_any) begin
          push_work.status = pidrt_pkg::ST_NO_SLOT;
        end else if (!aok_r) begin
          push_work.status = pidrt_pkg::ST_NO_ALLOC;
        end else begin
          push_work.op  = pidrt_pkg::OP_NEW;
          push_work.idx = pidrt_pkg::SIDX_W'(free_idx);
        end
      end
      pidrt_pkg::CMD_RELEASE: begin
        if (!hit_any) begin
          push_work.status = pidrt_pkg::ST_NOT_FOUND;
        end else begin
          push_work.idx = pidrt_pkg::SIDX_W'(hit_idx);
          if (is_owner && !holds_h) begin
            push_work.op = pidrt_pkg::OP_NOP;
          end else begin
            push_work.op        = pidrt_pkg::OP_REL;
            push_work.clr_owner = is_owner;
          end
        end
      end
      pidrt_pkg::CMD_DESTROY: begin
        push_work.op = pidrt_pkg::OP_DESTROY;
      end
      pidrt_pkg::CMD_CHECK: begin
        if (sidx_r < pidrt_pkg::SIDX_W'(ENTRIES)) begin
          push_work.op  = pidrt_pkg::OP_CHECK;
          push_work.idx = sidx_r;
        end
      end
      default: begin
        push_work.op = pidrt_pkg::OP_NOP;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/pidrt_back.sv
// Back of the handle table: holds the entry state and the handle memory,
// carries out one work request per cycle and registers the result. Uses pidrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pidrt_back #(
  parameter int ENTRIES    = 8,
  parameter int COUNT_BITS = 16,
  parameter int PID_BITS   = 22
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           pop,
  input  wire pidrt_pkg::work_t               work,
  input  wire logic [PID_BITS-1:0]            work_pid,
  input  wire logic                           rd_en,
  input  wire logic [pidrt_pkg::SIDX_W-1:0]   rd_idx,
  output logic [ENTRIES-1:0]                  live,
  output logic [ENTRIES-1:0]                  holds,
  output logic [ENTRIES*PID_BITS-1:0]         keys,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [pidrt_pkg::SLOT_W-1:0]        out_slot,
  output logic [pidrt_pkg::HANDLE_W-1:0]      out_chunk_handle,
  output logic                                out_chunk_valid,
  output logic                                out_free_request,
  output logic                                out_in_use,
  output logic                                out_aggregate_metrics,
  output logic [pidrt_pkg::FREED_W-1:0]       out_freed_count,
  output logic                                out_count_saturated
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  logic [PID_BITS-1:0]           key_r [ENTRIES];
  logic [COUNT_BITS-1:0]         cnt_r [ENTRIES];
  logic [ENTRIES-1:0]            holds_r;
  logic [pidrt_pkg::HANDLE_W-1:0] hnd_mem [ENTRIES];
  logic [pidrt_pkg::HANDLE_W-1:0] hnd_rd_r;

  logic [IDX_W-1:0]       idx;
  logic [COUNT_BITS-1:0]  cnt_cur;
  logic [COUNT_BITS-1:0]  cnt_inc;
  logic [COUNT_BITS-1:0]  cnt_dec;
  logic [CNT_W-1:0]       live_n;
  logic [CNT_W+3:0]       freed_ext;

  logic                           valid_r;
  logic [1:0]                     status_r,  status_nxt;
  logic [pidrt_pkg::SLOT_W-1:0]   slot_r,    slot_nxt;
  logic [pidrt_pkg::HANDLE_W-1:0] handle_r,  handle_nxt;
  logic                           cvalid_r,  cvalid_nxt;
  logic                           free_r,    free_nxt;
  logic                           inuse_r,   inuse_nxt;
  logic                           agg_r,     agg_nxt;
  logic [pidrt_pkg::FREED_W-1:0]  freed_r,   freed_nxt;
  logic                           sat_r,     sat_nxt;

  assign idx     = work.idx[IDX_W-1:0];
  assign cnt_cur = cnt_r[idx];
  assign cnt_inc = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + CNT_ONE;
  assign cnt_dec = cnt_cur - CNT_ONE;
  assign holds   = holds_r;

  always_comb begin
    live_n = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      live[i]                          = (cnt_r[i] != '0);
      keys[i*PID_BITS +: PID_BITS]     = key_r[i];
      live_n                           = live_n + CNT_W'(live[i]);
    end
    freed_ext = {4'b0000, live_n};
  end

  always_comb begin
    status_nxt = work.status;
    slot_nxt   = work.idx[pidrt_pkg::SLOT_W-1:0];
    handle_nxt = '0;
    cvalid_nxt = 1'b0;
    free_nxt   = 1'b0;
    inuse_nxt  = 1'b0;
    agg_nxt    = 1'b0;
    freed_nxt  = '0;
    sat_nxt    = 1'b0;
    case (work.op)
      pidrt_pkg::OP_NEW: begin
        handle_nxt = work.handle;
        cvalid_nxt = 1'b1;
        sat_nxt    = (CNT_ONE == CNT_MAX);
      end
      pidrt_pkg::OP_ACQ: begin
        handle_nxt = hnd_rd_r;
        cvalid_nxt = 1'b1;
        sat_nxt    = work.bump && (cnt_inc == CNT_MAX);
      end
      pidrt_pkg::OP_REL: begin
        agg_nxt = work.clr_owner;
        if (cnt_dec == '0) begin
          handle_nxt = hnd_rd_r;
          cvalid_nxt = 1'b1;
          free_nxt   = 1'b1;
        end
      end
      pidrt_pkg::OP_DESTROY: begin
        freed_nxt = freed_ext[pidrt_pkg::FREED_W-1:0];
      end
      pidrt_pkg::OP_CHECK: begin
        inuse_nxt = holds_r[idx];
      end
      default: begin
        status_nxt = work.status;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holds_r <= '0;
      valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        key_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      valid_r <= pop;
      if (pop) begin
        case (work.op)
          pidrt_pkg::OP_NEW: begin
            key_r[idx]   <= work_pid;
            holds_r[idx] <= 1'b1;
            cnt_r[idx]   <= CNT_ONE;
          end
          pidrt_pkg::OP_ACQ: begin
            if (work.set_owner) begin
              holds_r[idx] <= 1'b1;
            end
            if (work.bump) begin
              cnt_r[idx] <= cnt_inc;
            end
          end
          pidrt_pkg::OP_REL: begin
            if (work.clr_owner) begin
              holds_r[idx] <= 1'b0;
            end
            cnt_r[idx] <= cnt_dec;
            if (cnt_dec == '0) begin
              key_r[idx] <= '0;
            end
          end
          pidrt_pkg::OP_DESTROY: begin
            for (int i = 0; i < ENTRIES; i++) begin
              cnt_r[i] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (work.op == pidrt_pkg::OP_NEW)) begin
      hnd_mem[idx] <= work.handle;
    end
    if (rd_en) begin
      hnd_rd_r <= hnd_mem[rd_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      handle_r <= handle_nxt;
      cvalid_r <= cvalid_nxt;
      free_r   <= free_nxt;
      inuse_r  <= inuse_nxt;
      agg_r    <= agg_nxt;
      freed_r  <= freed_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign out_valid             = valid_r;
  assign out_status            = status_r;
  assign out_slot              = slot_r;
  assign out_chunk_handle      = handle_r;
  assign out_chunk_valid       = cvalid_r;
  assign out_free_request      = free_r;
  assign out_in_use            = inuse_r;
  assign out_aggregate_metrics = agg_r;
  assign out_freed_count       = freed_r;
  assign out_count_saturated   = sat_r;

endmodule
`default_nettype wire

FILE: rtl/pid_refcount_handle_table_top.sv
// Top level of the pid-keyed reference-counted handle table.
// Ties pidrt_front, pidrt_queue and pidrt_back together; uses pidrt_pkg.
//
// Usage:
//   Request channel: drive in_* and raise start; the request is taken at a
//   rising edge where start is high and busy is low.
//   Result channel: exactly one result per request, shown for one cycle
//   with out_valid high. The receiver cannot stall; sample on out_valid.
//   Flow: busy stays high until the request is pushed. The front holds a request for
//   its key match cycle, and the back does the read-modify-write of the
//   entry state in the next; the front classifies a request only once the
//   queue is empty, so every lookup sees the state the previous request
//   left behind.
//   Reset: synchronous, active low. All entries come up free with zero
//   counts and clear owner flags; no clearing pass is needed, so a request
//   may be given in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module pid_refcount_handle_table_top #(
  parameter int ENTRIES    = 8,
  parameter int COUNT_BITS = 16,
  parameter int PID_BITS   = 22
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       in_cmd,
  input  wire logic [PID_BITS-1:0]              in_key_pid,
  input  wire logic [PID_BITS-1:0]              in_caller_pid,
  input  wire logic [pidrt_pkg::SIDX_W-1:0]     in_slot_index,
  input  wire logic                             in_alloc_ok,
  input  wire logic [pidrt_pkg::HANDLE_W-1:0]   in_alloc_handle,
  output logic                                  out_valid,
  output logic [1:0]                            out_status,
  output logic [pidrt_pkg::SLOT_W-1:0]          out_slot,
  output logic [pidrt_pkg::HANDLE_W-1:0]        out_chunk_handle,
  output logic                                  out_chunk_valid,
  output logic                                  out_free_request,
  output logic                                  out_in_use,
  output logic                                  out_aggregate_metrics,
  output logic [pidrt_pkg::FREED_W-1:0]         out_freed_count,
  output logic                                  out_count_saturated
);

  localparam int QW = $bits(pidrt_pkg::work_t) + PID_BITS;

  logic [ENTRIES-1:0]          live;
  logic [ENTRIES-1:0]          holds;
  logic [ENTRIES*PID_BITS-1:0] keys;
  logic                        q_empty;
  logic                        q_full;
  logic                        push;
  pidrt_pkg::work_t            push_work;
  logic [PID_BITS-1:0]         push_pid;
  logic [QW-1:0]               pop_data;
  pidrt_pkg::work_t            pop_work;
  logic [PID_BITS-1:0]         pop_pid;
  logic                        pop;

  assign pop      = !q_empty;
  assign pop_work = pidrt_pkg::work_t'(pop_data[QW-1:PID_BITS]);
  assign pop_pid  = pop_data[PID_BITS-1:0];

  pidrt_front #(
    .ENTRIES  (ENTRIES),
    .PID_BITS (PID_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_key_pid      (in_key_pid),
    .in_caller_pid   (in_caller_pid),
    .in_slot_index   (in_slot_index),
    .in_alloc_ok     (in_alloc_ok),
    .in_alloc_handle (in_alloc_handle),
    .live            (live),
    .holds           (holds),
    .keys            (keys),
    .q_empty         (q_empty),
    .push            (push),
    .push_work       (push_work),
    .push_pid        (push_pid)
  );

  pidrt_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_work, push_pid}),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  pidrt_back #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS),
    .PID_BITS   (PID_BITS)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .pop                   (pop),
    .work                  (pop_work),
    .work_pid              (pop_pid),
    .rd_en                 (push),
    .rd_idx                (push_work.idx),
    .live                  (live),
    .holds                 (holds),
    .keys                  (keys),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_slot              (out_slot),
    .out_chunk_handle      (out_chunk_handle),
    .out_chunk_valid       (out_chunk_valid),
    .out_free_request      (out_free_request),
    .out_in_use            (out_in_use),
    .out_aggregate_metrics (out_aggregate_metrics),
    .out_freed_count       (out_freed_count),
    .out_count_saturated   (out_count_saturated)
  );

  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_push_never_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("push into a full queue");

  a_pop_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid)
    else $error("executed request gave no result");

  a_free_has_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_free_request) |->
      (out_chunk_valid && (out_status == pidrt_pkg::ST_OK)))
    else $error("free request without a valid handle");

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Self-checking bench for pid_refcount_handle_table_top: a directed table and
// random traffic, scored against typed replies or a behavioral table.
// Depends on pidrt_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb;
  import pidrt_pkg::*;

  localparam int ENTRIES     = 8;
  localparam int COUNT_BITS  = 16;
  localparam int PID_W       = 22;
  localparam int POOL_N      = 10;
  localparam int RAND_ITEMS  = 950;
  localparam int CYCLE_LIMIT = 40000;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [PID_W-1:0] PID_MAX = '1;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [PID_W-1:0]    pid_key;
    logic [PID_W-1:0]    caller;
    logic [SIDX_W-1:0]   sidx;
    logic                aok;
    logic [HANDLE_W-1:0] handle;
  } tbl_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] chunk_handle;
    logic                chunk_valid;
    logic                free_request;
    logic                in_use;
    logic                aggregate_metrics;
    logic [FREED_W-1:0]  freed_count;
    logic                count_saturated;
  } tbl_reply_t;

  typedef struct {
    tbl_req_t   rq;
    bit         typed;
    tbl_reply_t reply;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0]          in_cmd;
  logic [PID_W-1:0]    in_key_pid;
  logic [PID_W-1:0]    in_caller_pid;
  logic [SIDX_W-1:0]   in_slot_index;
  logic                in_alloc_ok;
  logic [HANDLE_W-1:0] in_alloc_handle;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [HANDLE_W-1:0] out_chunk_handle;
  logic                out_chunk_valid;
  logic                out_free_request;
  logic                out_in_use;
  logic                out_aggregate_metrics;
  logic [FREED_W-1:0]  out_freed_count;
  logic                out_count_saturated;

  logic [PID_W-1:0]      key_st [ENTRIES] = '{default: '0};
  logic                  own_st [ENTRIES] = '{default: 1'b0};
  logic [COUNT_BITS-1:0] cnt_st [ENTRIES] = '{default: '0};
  logic [HANDLE_W-1:0]   hdl_st [ENTRIES] = '{default: '0};

  logic [PID_W-1:0] pid_pool [POOL_N] = '{22'd1, 22'd2, 22'd3, 22'd7, 22'd100, 22'd12345,
                                          22'h155555, 22'h2AAAAA, 22'h200000, 22'h3FFFFF};

  tbl_reply_t reply_q [$];
  dir_row_t   dir_tbl [$];
  tbl_reply_t want;
  int         err_cnt = 0;
  int         idle_pct = 21;
  int         cycle_cnt = 0;

  pid_refcount_handle_table_top #(
    .ENTRIES(ENTRIES),
    .COUNT_BITS(COUNT_BITS),
    .PID_BITS(PID_W)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_key_pid(in_key_pid),
    .in_caller_pid(in_caller_pid),
    .in_slot_index(in_slot_index),
    .in_alloc_ok(in_alloc_ok),
    .in_alloc_handle(in_alloc_handle),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_slot(out_slot),
    .out_chunk_handle(out_chunk_handle),
    .out_chunk_valid(out_chunk_valid),
    .out_free_request(out_free_request),
    .out_in_use(out_in_use),
    .out_aggregate_metrics(out_aggregate_metrics),
    .out_freed_count(out_freed_count),
    .out_count_saturated(out_count_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic tbl_req_t mk_req(logic [1:0] cmd, logic [PID_W-1:0] pid_key,
                                      logic [PID_W-1:0] caller, logic [SIDX_W-1:0] sidx,
                                      logic aok, logic [HANDLE_W-1:0] handle);
    tbl_req_t rq;
    rq.cmd = cmd;
    rq.pid_key = pid_key;
    rq.caller = caller;
    rq.sidx = sidx;
    rq.aok = aok;
    rq.handle = handle;
    return rq;
  endfunction

  function automatic tbl_reply_t mk_reply(logic [1:0] status, logic [SLOT_W-1:0] slot,
                                          logic [HANDLE_W-1:0] handle, logic valid,
                                          logic [FREED_W-1:0] freed);
    tbl_reply_t rp;
    rp = '0;
    rp.status = status;
    rp.slot = slot;
    rp.chunk_handle = handle;
    rp.chunk_valid = valid;
    rp.freed_count = freed;
    return rp;
  endfunction

  function automatic int find_live(logic [PID_W-1:0] pid);
    for (int i = 0; i < ENTRIES; i++)
      if (cnt_st[i] != '0 && key_st[i] == pid) return i;
    return -1;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < ENTRIES; i++)
      if (cnt_st[i] == '0) return i;
    return -1;
  endfunction

  function automatic logic bump_count(int s);
    if (cnt_st[s] != CNT_MAX) cnt_st[s] = cnt_st[s] + 1'b1;
    return cnt_st[s] == CNT_MAX;
  endfunction

  function automatic tbl_reply_t table_apply(tbl_req_t rq);
    tbl_reply_t rp;
    int s;
    int n;
    rp = '0;
    n = 0;
    case (rq.cmd)
      CMD_ACQUIRE: begin
        s = find_live((rq.pid_key == '0) ? rq.caller : rq.pid_key);
        if (s < 0 && rq.pid_key != '0) begin
          rp.status = ST_NOT_FOUND;
        end else if (s < 0) begin
          s = find_free();
          if (s < 0) begin
            rp.status = ST_NO_SLOT;
          end else if (!rq.aok) begin
            rp.status = ST_NO_ALLOC;
          end else begin
            key_st[s] = rq.caller;
            own_st[s] = 1'b1;
            cnt_st[s] = 1;
            hdl_st[s] = rq.handle;
            rp.slot = SLOT_W'(s);
            rp.chunk_handle = rq.handle;
            rp.chunk_valid = 1'b1;
            rp.count_saturated = (cnt_st[s] == CNT_MAX);
          end
        end else begin
          rp.slot = SLOT_W'(s);
          rp.chunk_handle = hdl_st[s];
          rp.chunk_valid = 1'b1;
          if (key_st[s] != rq.caller) begin
            rp.count_saturated = bump_count(s);
          end else if (!own_st[s]) begin
            own_st[s] = 1'b1;
            rp.count_saturated = bump_count(s);
          end
        end
      end
      CMD_RELEASE: begin
        s = find_live((rq.pid_key == '0) ? rq.caller : rq.pid_key);
        if (s < 0) begin
          rp.status = ST_NOT_FOUND;
        end else begin
          rp.slot = SLOT_W'(s);
          if (!(key_st[s] == rq.caller && !own_st[s])) begin
            if (key_st[s] == rq.caller) begin
              own_st[s] = 1'b0;
              rp.aggregate_metrics = 1'b1;
            end
            cnt_st[s] = cnt_st[s] - 1'b1;
            if (cnt_st[s] == '0) begin
              rp.chunk_handle = hdl_st[s];
              rp.chunk_valid = 1'b1;
              rp.free_request = 1'b1;
              key_st[s] = '0;
            end
          end
        end
      end
      CMD_DESTROY: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (cnt_st[i] != '0) begin
            cnt_st[i] = '0;
            n++;
          end
        end
        rp.freed_count = FREED_W'(n);
      end
      default: begin
        if (rq.sidx < ENTRIES) begin
          rp.slot = SLOT_W'(rq.sidx);
          rp.in_use = own_st[rq.sidx];
        end
      end
    endcase
    return rp;
  endfunction

  function automatic logic [PID_W-1:0] pick_pid();
    if ($urandom_range(99) < 85) return pid_pool[$urandom_range(POOL_N - 1)];
    return PID_W'($urandom_range(32'h3FFFFF, 1));
  endfunction

  function automatic tbl_req_t random_request();
    tbl_req_t rq;
    int live_q [$];
    int pick;
    int r;
    for (int i = 0; i < ENTRIES; i++)
      if (cnt_st[i] != '0) live_q.push_back(i);
    pick = (live_q.size() != 0) ? live_q[$urandom_range(live_q.size() - 1)] : -1;
    rq.cmd = CMD_CHECK;
    rq.pid_key = '0;
    rq.caller = pick_pid();
    rq.sidx = ($urandom_range(99) < 80) ? SIDX_W'($urandom_range(9)) :
                                          SIDX_W'($urandom_range(255));
    rq.aok = ($urandom_range(99) < 88);
    rq.handle = $urandom;
    r = $urandom_range(99);
    if (r < 72) begin
      rq.cmd = (r < 38) ? CMD_ACQUIRE : CMD_RELEASE;
      if (pick >= 0 && $urandom_range(99) < 75) begin
        if ($urandom_range(1) == 1) rq.pid_key = key_st[pick];
        else rq.caller = key_st[pick];
        if ($urandom_range(99) < 30) rq.caller = key_st[pick];
      end else if ($urandom_range(1) == 1) begin
        rq.pid_key = pick_pid();
      end
    end else if (r < 74) begin
      rq.cmd = CMD_DESTROY;
    end
    return rq;
  endfunction

  task automatic send(tbl_req_t rq, bit typed, tbl_reply_t typed_reply);
    tbl_reply_t pred;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    in_cmd = rq.cmd;
    in_key_pid = rq.pid_key;
    in_caller_pid = rq.caller;
    in_slot_index = rq.sidx;
    in_alloc_ok = rq.aok;
    in_alloc_handle = rq.handle;
    start = 1'b1;
    do @(posedge clk); while (busy);
    pred = table_apply(rq);
    reply_q.push_back(typed ? typed_reply : pred);
  endtask

  // hold off until every owed reply is back
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_reply(tbl_reply_t exp_r);
    if (out_status !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, out_status);
      err_cnt++;
    end
    if (out_slot !== exp_r.slot) begin
      $error("slot: expected %0d, got %0d", exp_r.slot, out_slot);
      err_cnt++;
    end
    if (out_chunk_handle !== exp_r.chunk_handle) begin
      $error("chunk_handle: expected %h, got %h", exp_r.chunk_handle, out_chunk_handle);
      err_cnt++;
    end
    if (out_chunk_valid !== exp_r.chunk_valid) begin
      $error("chunk_valid: expected %0d, got %0d", exp_r.chunk_valid, out_chunk_valid);
      err_cnt++;
    end
    if (out_free_request !== exp_r.free_request) begin
      $error("free_request: expected %0d, got %0d", exp_r.free_request, out_free_request);
      err_cnt++;
    end
    if (out_in_use !== exp_r.in_use) begin
      $error("in_use: expected %0d, got %0d", exp_r.in_use, out_in_use);
      err_cnt++;
    end
    if (out_aggregate_metrics !== exp_r.aggregate_metrics) begin
      $error("aggregate_metrics: expected %0d, got %0d", exp_r.aggregate_metrics,
             out_aggregate_metrics);
      err_cnt++;
    end
    if (out_freed_count !== exp_r.freed_count) begin
      $error("freed_count: expected %0d, got %0d", exp_r.freed_count, out_freed_count);
      err_cnt++;
    end
    if (out_count_saturated !== exp_r.count_saturated) begin
      $error("count_saturated: expected %0d, got %0d", exp_r.count_saturated,
             out_count_saturated);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (reply_q.size() == 0) begin
        $error("reply with no request outstanding");
        err_cnt++;
      end else begin
        want = reply_q.pop_front();
        check_reply(want);
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    start = 1'b0;
    in_cmd = CMD_CHECK;
    in_key_pid = '0;
    in_caller_pid = '0;
    in_slot_index = '0;
    in_alloc_ok = 1'b0;
    in_alloc_handle = '0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    dir_tbl.push_back('{mk_req(CMD_CHECK, '0, 22'd1, 8'd0, 1'b0, '0), 1'b1,
                        mk_reply(ST_OK, 3'd0, '0, 1'b0, '0)});
    dir_tbl.push_back('{mk_req(CMD_CHECK, '0, 22'd1, 8'd255, 1'b0, '0), 1'b1,
                        mk_reply(ST_OK, 3'd0, '0, 1'b0, '0)});
    dir_tbl.push_back('{mk_req(CMD_RELEASE, '0, 22'd5, 8'd0, 1'b1, '0), 1'b1,
                        mk_reply(ST_NOT_FOUND, 3'd0, '0, 1'b0, '0)});
    dir_tbl.push_back('{mk_req(CMD_ACQUIRE, '0, 22'd5, 8'd0, 1'b0, 32'h1234), 1'b1,
                        mk_reply(ST_NO_ALLOC, 3'd0, '0, 1'b0, '0)});
    dir_tbl.push_back('{mk_req(CMD_ACQUIRE, '0, 22'd1, 8'd0, 1'b1, '1), 1'b1,
                        mk_reply(ST_OK, 3'd0, '1, 1'b1, '0)});
    dir_tbl.push_back('{mk_req(CMD_ACQUIRE, '0, PID_MAX, 8'd0, 1'b1, '0), 1'b1,
                        mk_reply(ST_OK, 3'd1, '0, 1'b1, '0)});
    dir_tbl.push_back('{mk_req(CMD_ACQUIRE, '0, 22'd1, 8'd0, 1'b1, 32'h77), 1'b0, '0});
    dir_tbl.push_back('{mk_req(CMD_ACQUIRE, 22'd1, PID_MAX, 8'd0, 1'b1, '0), 1'b0, '0});
    dir_tbl.push_back('{mk_req(CMD_ACQUIRE, PID_MAX, PID_MAX, 8'd0, 1'b1, '0), 1'b0, '0});
    dir_tbl.push_back('{mk_req(CMD_RELEASE, '0, 22'd1, 8'd0, 1'b0, '0), 1'b0, '0});
    dir_tbl.push_back('{mk_req(CMD_RELEASE, '0, 22'd1, 8'd0, 1'b0, '0), 1'b0, '0});
    dir_tbl.push_back('{mk_req(CMD_CHECK, '0, 22'd1, 8'd0, 1'b0, '0), 1'b0, '0});
    dir_tbl.push_back('{mk_req(CMD_ACQUIRE, 22'd1, 22'd1, 8'd0, 1'b1, '0), 1'b0, '0});
    dir_tbl.push_back('{mk_req(CMD_RELEASE, 22'd1, 22'd7, 8'd0, 1'b0, '0), 1'b0, '0});
    dir_tbl.push_back('{mk_req(CMD_RELEASE, 22'd1, 22'd1, 8'd0, 1'b0, '0), 1'b0, '0});
    dir_tbl.push_back('{mk_req(CMD_ACQUIRE, 22'd77, 22'd9, 8'd0, 1'b1, '0), 1'b1,
                        mk_reply(ST_NOT_FOUND, 3'd0, '0, 1'b0, '0)});
    for (int i = 0; i < ENTRIES - 1; i++)
      dir_tbl.push_back('{mk_req(CMD_ACQUIRE, '0, PID_W'(10 + i), 8'd0, 1'b1, $urandom),
                          1'b0, '0});
    dir_tbl.push_back('{mk_req(CMD_ACQUIRE, '0, 22'd20, 8'd0, 1'b1, 32'h55), 1'b1,
                        mk_reply(ST_NO_SLOT, 3'd0, '0, 1'b0, '0)});
    dir_tbl.push_back('{mk_req(CMD_DESTROY, '0, 22'd1, 8'd0, 1'b0, '0), 1'b1,
                        mk_reply(ST_OK, 3'd0, '0, 1'b0, 4'd8)});
    dir_tbl.push_back('{mk_req(CMD_CHECK, '0, 22'd1, 8'd7, 1'b0, '0), 1'b0, '0});

    foreach (dir_tbl[i]) send(dir_tbl[i].rq, dir_tbl[i].typed, dir_tbl[i].reply);
    drain();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      idle_pct = (i >= 250 && i < 500) ? 0 : 21;
      if (i == 600) drain();
      send(random_request(), 1'b0, '0);
    end
    drain();
    repeat (4) @(posedge clk);

    if (err_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
